/* rtl/core/rgbds_pkg.sv */
package rgbds_pkg;

  // Line store geometry. The widest line held is MAX_WIDTH pixels.
  localparam int MAX_WIDTH    = 4096;
  localparam int LINE_ENTRIES = MAX_WIDTH / 2;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int LINE_ADDR_W  = COL_W - 1;

  // Row counter wraps at this many rows whatever the height register says.
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Size registers and channel widths.
  localparam int DIM_W  = 13;
  localparam int CHAN_W = 8;
  localparam int PAIR_W = CHAN_W + 1;
  localparam int QUAD_W = CHAN_W + 2;

  // Common width for position against size compares.
  localparam int CMP_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;

  // Largest width the line store can take, as seen through the register width.
  localparam int MAX_W_DIM = (MAX_WIDTH > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_WIDTH;

  // Reset sizes.
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  // APB port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [0:0] {
    REG_IN_WIDTH  = 1'b0,
    REG_IN_HEIGHT = 1'b1
  } reg_idx_t;

  // Sizes as the datapath uses them, after clamping.
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  // One line store entry: three horizontal pair sums, red in the low bits.
  typedef struct packed {
    logic [PAIR_W-1:0] blue;
    logic [PAIR_W-1:0] green;
    logic [PAIR_W-1:0] red;
  } pair_sum_t;

  // Access request to the line store.
  typedef struct packed {
    logic                   we;
    logic [LINE_ADDR_W-1:0] waddr;
    pair_sum_t              wdata;
    logic                   re;
    logic [LINE_ADDR_W-1:0] raddr;
  } line_req_t;

  // Rounded mean of two pair sums: (a + b + 2) / 4.
  function automatic logic [CHAN_W-1:0] quad_mean(input logic [PAIR_W-1:0] a,
                                                  input logic [PAIR_W-1:0] b);
    logic [QUAD_W-1:0] sum;
    sum = QUAD_W'(a) + QUAD_W'(b) + QUAD_W'(2);
    return sum[QUAD_W-1:2];
  endfunction

endpackage

/* rtl/core/rgbds_cfg_regs.sv */
module rgbds_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rgbds_pkg::PADDR_W-1:0]   paddr,
  input  logic [rgbds_pkg::PDATA_W-1:0]   pwdata,
  output logic [rgbds_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  output rgbds_pkg::dims_t                dims
);
  import rgbds_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] width_nxt;
  logic [DIM_W-1:0] height_r;
  logic [DIM_W-1:0] height_nxt;
  logic             wr_en;
  reg_idx_t         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  // Register write decode.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (reg_idx)
        REG_IN_WIDTH:  width_nxt  = pwdata[DIM_W-1:0];
        REG_IN_HEIGHT: height_nxt = pwdata[DIM_W-1:0];
        default: begin
          width_nxt  = width_r;
          height_nxt = height_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Read back the raw register values.
  always_comb begin
    case (reg_idx)
      REG_IN_WIDTH:  prdata = PDATA_W'(width_r);
      REG_IN_HEIGHT: prdata = PDATA_W'(height_r);
      default:       prdata = '0;
    endcase
  end

  // A zero size acts as one; the width is limited to the line store.
  always_comb begin
    if (width_r == '0) begin
      dims.width = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_W_DIM)) begin
      dims.width = DIM_W'(MAX_W_DIM);
    end else begin
      dims.width = width_r;
    end
    dims.height = (height_r == '0) ? DIM_W'(1) : height_r;
  end

endmodule

/* rtl/core/rgbds_line_store.sv */
module rgbds_line_store (
  input  logic                  clk,
  input  rgbds_pkg::line_req_t  req,
  output rgbds_pkg::pair_sum_t  rd_data
);
  import rgbds_pkg::*;

  pair_sum_t mem [LINE_ENTRIES];
  pair_sum_t rd_data_r;

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/rgb_two_by_two_downsampler_unit.sv */
// A pixel that completes a 2x2 block passes through the holding stage and then the output register.
// Throughput: one pixel per cycle while the output does not stall; the line store has separate
// read and write ports, and the pair sum of a row is read back at least two beats after it was written.
// Output stalls back up through one holding stage and then stall the input.
// Reset (rst_n, synchronous, active low) clears the position counters and the pipeline
// valids and sets the size registers to 640 x 480; the line store is not cleared.
module rgb_two_by_two_downsampler_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Pixel input.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rgbds_pkg::CHAN_W-1:0]        in_red,
  input  logic [rgbds_pkg::CHAN_W-1:0]        in_green,
  input  logic [rgbds_pkg::CHAN_W-1:0]        in_blue,
  // Downsampled output.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rgbds_pkg::CHAN_W-1:0]        out_red,
  output logic [rgbds_pkg::CHAN_W-1:0]        out_green,
  output logic [rgbds_pkg::CHAN_W-1:0]        out_blue,
  output logic                                out_row_done,
  output logic                                out_frame_done,
  // Configuration.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rgbds_pkg::PADDR_W-1:0]       paddr,
  input  logic [rgbds_pkg::PDATA_W-1:0]       pwdata,
  output logic [rgbds_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);
  import rgbds_pkg::*;

  dims_t     dims;
  line_req_t line_req;
  pair_sum_t line_rd;

  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  row_nxt;
  logic [CHAN_W-1:0] left_red_r;
  logic [CHAN_W-1:0] left_green_r;
  logic [CHAN_W-1:0] left_blue_r;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  pair_sum_t         s1_pair_r;
  logic              s1_row_done_r;
  logic              s1_frame_done_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CHAN_W-1:0] out_red_r;
  logic [CHAN_W-1:0] out_green_r;
  logic [CHAN_W-1:0] out_blue_r;
  logic              out_row_done_r;
  logic              out_frame_done_r;

  logic              accept;
  logic              s1_adv;
  logic [CMP_W-1:0]  col_ext;
  logic [CMP_W-1:0]  row_ext;
  logic [CMP_W-1:0]  w_ext;
  logic [CMP_W-1:0]  h_ext;
  logic [CMP_W-1:0]  w_even;
  logic [CMP_W-1:0]  h_even;
  logic              pair_ok;
  logic              store_pair;
  logic              emit;
  logic              col_wrap;
  logic              row_wrap;
  logic              row_done;
  logic              frame_done;
  pair_sum_t         cur_pair;

  rgbds_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  rgbds_line_store u_line_store (
    .clk     (clk),
    .req     (line_req),
    .rd_data (line_rd)
  );

  // Handshake: the holding stage moves on when the output register is free.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // Position against the frame size.
  assign col_ext = CMP_W'(col_r);
  assign row_ext = CMP_W'(row_r);
  assign w_ext   = CMP_W'(dims.width);
  assign h_ext   = CMP_W'(dims.height);
  assign w_even  = {w_ext[CMP_W-1:1], 1'b0};
  assign h_even  = {h_ext[CMP_W-1:1], 1'b0};

  assign pair_ok    = col_r[0] && (col_ext < w_ext);
  assign store_pair = pair_ok && !row_r[0];
  assign emit       = pair_ok && row_r[0] && (row_ext < h_ext);
  assign col_wrap   = (col_ext + CMP_W'(1)) >= w_ext;
  assign row_wrap   = ((row_ext + CMP_W'(1)) >= h_ext) || (row_r == {ROW_W{1'b1}});
  assign row_done   = (col_ext + CMP_W'(1)) == w_even;
  assign frame_done = row_done && ((row_ext + CMP_W'(1)) == h_even);

  // Horizontal pair sum of the stored left pixel and the current one.
  assign cur_pair.red   = PAIR_W'(left_red_r) + PAIR_W'(in_red);
  assign cur_pair.green = PAIR_W'(left_green_r) + PAIR_W'(in_green);
  assign cur_pair.blue  = PAIR_W'(left_blue_r) + PAIR_W'(in_blue);

  // Even rows write the pair sum, odd rows read it back.
  always_comb begin
    line_req.we    = accept && store_pair;
    line_req.waddr = col_r[COL_W-1:1];
    line_req.wdata = cur_pair;
    line_req.re    = accept && emit;
    line_req.raddr = col_r[COL_W-1:1];
  end

  // Next position in raster order.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Left pixel of the pair on even columns.
  always_ff @(posedge clk) begin
    if (accept && !col_r[0]) begin
      left_red_r   <= in_red;
      left_green_r <= in_green;
      left_blue_r  <= in_blue;
    end
  end

  // Holding stage: waits for the registered line store read data.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = emit;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_pair_r       <= cur_pair;
      s1_row_done_r   <= row_done;
      s1_frame_done_r <= frame_done;
    end
  end

  // Output register with the rounded block mean.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_red_r        <= quad_mean(s1_pair_r.red, line_rd.red);
      out_green_r      <= quad_mean(s1_pair_r.green, line_rd.green);
      out_blue_r       <= quad_mean(s1_pair_r.blue, line_rd.blue);
      out_row_done_r   <= s1_row_done_r;
      out_frame_done_r <= s1_frame_done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_row_done   = out_row_done_r;
  assign out_frame_done = out_frame_done_r;

`ifndef SYNTHESIS
  // The input is only held back while a finished block waits behind a full output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked holding stage");

  // A held block stays in the holding stage while the input is stalled.
  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid_r)
    else $error("holding stage lost a block during a stall");

  // A read never hits the entry written in the cycle before, so no bypass is needed.
  a_no_rw_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (line_req.re && $past(line_req.we)) |-> (line_req.raddr != $past(line_req.waddr)))
    else $error("line store read follows a write to the same entry");

  // End of frame is always also end of an output row.
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_done_r) |-> out_row_done_r)
    else $error("frame end without row end");

  // Reads and writes of the line store come only from accepted beats.
  a_line_access: assert property (@(posedge clk) disable iff (!rst_n)
    (line_req.we || line_req.re) |-> (accept && !(line_req.we && line_req.re)))
    else $error("line store accessed outside an accepted beat");
`endif

endmodule
